// ----- hdl/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants for the contrast stretch and pseudocolor pipe.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned ProdW   = SampleW + DiffW;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned RegIdxW = 3;

  // Register indexes of the configuration port.
  localparam logic [RegIdxW-1:0] REG_DOMAIN_LOW   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_BREAK_LOW    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_BREAK_HIGH   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DOMAIN_HIGH  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SLOPE_LOW    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SLOPE_MID    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SLOPE_HIGH   = 3'd6;
  localparam logic [RegIdxW-1:0] REG_PALETTE_MODE = 3'd7;

  // Stretch anchors (integer) and Q8.8 band edges.
  localparam logic [ChanW-1:0] BaseLow   = 8'd10;
  localparam logic [ChanW-1:0] BaseHigh  = 8'd245;
  localparam logic [ChanW-1:0] GreyLand  = 8'd128;
  localparam logic [ChanW-1:0] ChanFull  = 8'd255;
  localparam logic [15:0]      VMax      = 16'd65280;
  localparam logic [15:0]      V4Band1   = 16'd16320;
  localparam logic [15:0]      V4Band2   = 16'd32640;
  localparam logic [15:0]      V4Band3   = 16'd48960;
  localparam logic [15:0]      V3Band1   = 16'd21760;
  localparam logic [15:0]      V3Band2   = 16'd43520;

  typedef enum logic [1:0] {
    KIND_WHITE,
    KIND_GREY,
    KIND_BLACK,
    KIND_STRETCH
  } pix_kind_e;

  typedef struct packed {
    logic signed [SampleW-1:0] domain_low;
    logic signed [SampleW-1:0] break_low;
    logic signed [SampleW-1:0] break_high;
    logic signed [SampleW-1:0] domain_high;
    logic signed [SampleW-1:0] slope_low;
    logic signed [SampleW-1:0] slope_mid;
    logic signed [SampleW-1:0] slope_high;
    logic                      palette_mode;
  } cfg_t;

  typedef struct packed {
    pix_kind_e                 kind;
    logic [ChanW-1:0]          base;
    logic signed [SampleW-1:0] slope;
    logic signed [DiffW-1:0]   diff;
  } seg_t;

  typedef struct packed {
    pix_kind_e               kind;
    logic [ChanW-1:0]        base;
    logic signed [ProdW-1:0] prod;
  } prod_t;

endpackage

// ----- hdl/lsp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lsp_cfg_regs
// Configuration register file written through the index/data channel.
// ----------------------------------------------------------------------------
module lsp_cfg_regs
  import lsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [SampleW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DOMAIN_LOW:   cfg_d.domain_low   = cfg_data_i;
        REG_BREAK_LOW:    cfg_d.break_low    = cfg_data_i;
        REG_BREAK_HIGH:   cfg_d.break_high   = cfg_data_i;
        REG_DOMAIN_HIGH:  cfg_d.domain_high  = cfg_data_i;
        REG_SLOPE_LOW:    cfg_d.slope_low    = cfg_data_i;
        REG_SLOPE_MID:    cfg_d.slope_mid    = cfg_data_i;
        REG_SLOPE_HIGH:   cfg_d.slope_high   = cfg_data_i;
        REG_PALETTE_MODE: cfg_d.palette_mode = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/lsp_seg_select.sv -----
// ----------------------------------------------------------------------------
// lsp_seg_select
// Input register, pixel classification and stretch segment selection.
// ----------------------------------------------------------------------------
module lsp_seg_select
  import lsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               sample_invalid_i,
  input  logic               cloud_i,
  input  logic               land_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output seg_t               out_o
);

  localparam logic signed [SampleW-1:0] SMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SMin = {1'b1, {(SampleW-1){1'b0}}};

  logic                      in_vld_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      invalid_q, cloud_q, land_q;
  logic                      seg_vld_q;
  seg_t                      seg_q, seg_d;
  logic                      seg_ready;
  logic signed [SampleW-1:0] x1, x2;
  logic signed [DiffW-1:0]   s_ext, x1_ext, x2_ext;

  assign seg_ready  = !seg_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || seg_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q  <= sample_i;
      invalid_q <= sample_invalid_i;
      cloud_q   <= cloud_i;
      land_q    <= land_i;
    end
  end

  // Clamp the breakpoints one LSB inside the domain, saturating at the ends.
  always_comb begin
    x1 = cfg_i.break_low;
    if (cfg_i.break_low < cfg_i.domain_low) begin
      x1 = (cfg_i.domain_low == SMax) ? SMax : cfg_i.domain_low + 32'sd1;
    end
    x2 = cfg_i.break_high;
    if (cfg_i.break_high > cfg_i.domain_high) begin
      x2 = (cfg_i.domain_high == SMin) ? SMin : cfg_i.domain_high - 32'sd1;
    end
  end

  assign s_ext  = {sample_q[SampleW-1], sample_q};
  assign x1_ext = {x1[SampleW-1], x1};
  assign x2_ext = {x2[SampleW-1], x2};

  always_comb begin
    seg_d = '0;
    if (cloud_q) begin
      seg_d.kind = KIND_WHITE;
    end else if (land_q) begin
      seg_d.kind = KIND_GREY;
    end else if (invalid_q || sample_q < cfg_i.domain_low ||
                 sample_q > cfg_i.domain_high) begin
      seg_d.kind = KIND_BLACK;
    end else begin
      seg_d.kind = KIND_STRETCH;
    end

    if (sample_q < x1) begin
      seg_d.base  = BaseLow;
      seg_d.slope = cfg_i.slope_low;
      seg_d.diff  = s_ext - x1_ext;
    end else if (sample_q > x2) begin
      seg_d.base  = BaseHigh;
      seg_d.slope = cfg_i.slope_high;
      seg_d.diff  = s_ext - x2_ext;
    end else begin
      seg_d.base  = BaseLow;
      seg_d.slope = cfg_i.slope_mid;
      seg_d.diff  = s_ext - x1_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q <= 1'b0;
    end else if (seg_ready) begin
      seg_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_ready && in_vld_q) begin
      seg_q <= seg_d;
    end
  end

  assign out_valid_o = seg_vld_q;
  assign out_o       = seg_q;

endmodule

// ----- hdl/lsp_mult.sv -----
// ----------------------------------------------------------------------------
// lsp_mult
// Registered slope by offset product in Q32.
// ----------------------------------------------------------------------------
module lsp_mult
  import lsp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  seg_t  in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output prod_t out_o
);

  logic                    vld_q;
  prod_t                   prod_q;
  logic signed [ProdW-1:0] prod;

  assign in_ready_o = !vld_q || out_ready_i;
  assign prod       = in_i.slope * in_i.diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q.kind <= in_i.kind;
      prod_q.base <= in_i.base;
      prod_q.prod <= prod;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = prod_q;

endmodule

// ----- hdl/lsp_palette.sv -----
// ----------------------------------------------------------------------------
// lsp_palette
// Q8.8 rounding, range check and palette lookup into the result register.
// ----------------------------------------------------------------------------
module lsp_palette
  import lsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             palette_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  prod_t            in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o,
  output logic             range_warning_o
);

  localparam int unsigned ShW = ProdW - 24;
  localparam int unsigned VW  = ShW + 1;

  logic                    vld_q;
  logic [ChanW-1:0]        red_q, green_q, blue_q, red_d, green_d, blue_d;
  logic                    warn_q, warn_d;
  logic signed [ProdW-1:0] rnd;
  logic signed [ShW-1:0]   sh;
  logic signed [VW-1:0]    v;
  logic [15:0]             v16;
  logic [15:0]             d4;
  logic [17:0]             t3;
  logic [15:0]             d3;

  assign in_ready_o = !vld_q || out_ready_i;

  // Round to nearest Q8.8, ties toward plus infinity; the shift is a floor.
  assign rnd = in_i.prod + $signed({{(ProdW-24){1'b0}}, 24'h800000});
  assign sh  = rnd[ProdW-1:24];
  assign v   = $signed({sh[ShW-1], sh}) +
               $signed({{(VW-16){1'b0}}, in_i.base, 8'h00});
  assign v16 = v[15:0];

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    warn_d  = 1'b0;
    d4      = '0;
    d3      = '0;
    t3      = '0;
    case (in_i.kind)
      KIND_WHITE: begin
        red_d   = ChanFull;
        green_d = ChanFull;
        blue_d  = ChanFull;
      end
      KIND_GREY: begin
        red_d   = GreyLand;
        green_d = GreyLand;
        blue_d  = GreyLand;
      end
      KIND_STRETCH: begin
        if (v[VW-1] || v > $signed({{(VW-16){1'b0}}, VMax})) begin
          warn_d = 1'b1;
        end else if (!palette_mode_i) begin
          if (v16 <= V4Band1) begin
            green_d = v16[13:6];
            blue_d  = ChanFull;
          end else if (v16 <= V4Band2) begin
            d4      = v16 - V4Band1;
            green_d = ChanFull;
            blue_d  = ChanFull - d4[13:6];
          end else if (v16 <= V4Band3) begin
            d4      = v16 - V4Band2;
            red_d   = ChanFull - d4[13:6];
            green_d = ChanFull;
          end else begin
            d4      = v16 - V4Band3;
            red_d   = ChanFull;
            green_d = ChanFull - d4[13:6];
          end
        end else begin
          if (v16 <= V3Band1) begin
            d3      = v16;
            t3      = {d3, 1'b0} + {2'b00, d3};
            red_d   = t3[15:8];
            green_d = ChanFull;
          end else begin
            d3      = (v16 <= V3Band2) ? v16 - V3Band1 : v16 - V3Band2;
            t3      = {d3, 1'b0} + {2'b00, d3};
            red_d   = ChanFull;
            green_d = ChanFull - t3[15:8];
          end
        end
      end
      default: begin
        red_d   = '0;
        green_d = '0;
        blue_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      warn_q  <= warn_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;
  assign range_warning_o = warn_q;

endmodule

// ----- hdl/linear_stretch_pseudocolor.sv -----
// ----------------------------------------------------------------------------
// linear_stretch_pseudocolor
// Three-segment contrast stretch of Q15.16 samples with a pseudocolor palette.
// ----------------------------------------------------------------------------
//   Channel   Signals                       Payload (lowest bit first)
//   s_axis    tvalid/tready/tdata/tuser     tdata: sample; tuser: invalid,
//                                           cloud, land
//   m_axis    tvalid/tready/tdata/tuser     tdata: red, green, blue;
//                                           tuser: range_warning
//   cfg       valid/ready/index/data        register index, write data
//
// One pixel is taken per clock while the output is not stalled, since every
// stage accepts a new pixel while it hands its own one on. After the input
// transfer the pixel passes the input, segment, product and result registers
// in turn, and the 32 by 33 bit slope multiplier has its own stage.
// Reset clears all configuration registers and empties every stage.
// A stall on the output holds each full stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module linear_stretch_pseudocolor
  import lsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,   // sample
  input  logic [2:0]         s_axis_tuser_i,   // sample_invalid, cloud, land
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,   // red, green, blue
  output logic               m_axis_tuser_o,   // range_warning
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [SampleW-1:0] cfg_data_i
);

  cfg_t             cfg;
  logic             seg_valid, seg_ready;
  seg_t             seg;
  logic             prod_valid, prod_ready;
  prod_t            prod;
  logic [ChanW-1:0] red, green, blue;

  lsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsp_seg_select u_seg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .sample_i         (s_axis_tdata_i),
    .sample_invalid_i (s_axis_tuser_i[0]),
    .cloud_i          (s_axis_tuser_i[1]),
    .land_i           (s_axis_tuser_i[2]),
    .out_valid_o      (seg_valid),
    .out_ready_i      (seg_ready),
    .out_o            (seg)
  );

  lsp_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_valid),
    .in_ready_o  (seg_ready),
    .in_i        (seg),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_o       (prod)
  );

  lsp_palette u_pal (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .palette_mode_i  (cfg.palette_mode),
    .in_valid_i      (prod_valid),
    .in_ready_o      (prod_ready),
    .in_i            (prod),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .range_warning_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {blue, green, red};

endmodule
